FILE: src/isdv_pkg.sv
package isdv_pkg;

    localparam int MAX_INTERVALS_DEF = 16;
    localparam int VALUE_WIDTH_DEF   = 32;

    localparam int OUT_WIDTH = 32;
    localparam int CNT_WIDTH = 5;
    localparam logic [CNT_WIDTH-1:0] CNT_RESET = 5'd1;

    localparam logic [OUT_WIDTH-1:0] OUT_MAX = 32'hFFFF_FFFF;

    // item kinds carried in s_tuser
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_VALUE = 2'd1;
    localparam logic [1:0] MODE_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    typedef struct packed {
        logic start;
        logic is_range;
    } walk_cmd_t;

endpackage

FILE: src/isdv_table.sv
module isdv_table #(
    parameter int DEPTH = isdv_pkg::MAX_INTERVALS_DEF,
    parameter int WIDTH = 2 * isdv_pkg::VALUE_WIDTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/isdv_walk.sv
module isdv_walk #(
    parameter int MAX_INTERVALS = isdv_pkg::MAX_INTERVALS_DEF,
    parameter int VALUE_WIDTH   = isdv_pkg::VALUE_WIDTH_DEF,
    parameter int AW            = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  isdv_pkg::walk_cmd_t               cmd,
    input  logic signed [VALUE_WIDTH-1:0]     arg_low,
    input  logic signed [VALUE_WIDTH-1:0]     arg_high,
    input  logic [AW-1:0]                     last_index,
    input  logic [2*VALUE_WIDTH-1:0]          rdata,
    output logic                              re,
    output logic [AW-1:0]                     raddr,
    output logic                              busy,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [isdv_pkg::OUT_WIDTH-1:0]    violation,
    output logic [isdv_pkg::OUT_WIDTH-1:0]    max_violation
);

    localparam int OW = isdv_pkg::OUT_WIDTH;
    localparam int GW = 65;

    // x - y clamped to [0, OUT_MAX]
    function automatic logic [OW-1:0] gap(input logic signed [VALUE_WIDTH-1:0] x,
                                          input logic signed [VALUE_WIDTH-1:0] y);
        logic signed [GW-1:0] d;
        logic [OW-1:0] r;
        d = GW'(x) - GW'(y);
        if (d <= 0)
            r = '0;
        else if (d > $signed({{(GW-OW){1'b0}}, isdv_pkg::OUT_MAX}))
            r = isdv_pkg::OUT_MAX;
        else
            r = d[OW-1:0];
        return r;
    endfunction

    function automatic logic [OW-1:0] umin(input logic [OW-1:0] x, input logic [OW-1:0] y);
        return (x < y) ? x : y;
    endfunction

    isdv_pkg::state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] last_reg, last_next;
    logic          range_reg, range_next;
    logic signed [VALUE_WIDTH-1:0] lo_reg, lo_next;
    logic signed [VALUE_WIDTH-1:0] hi_reg, hi_next;
    logic signed [VALUE_WIDTH-1:0] prev_reg, prev_next;
    logic [OW-1:0] a_reg, a_next;
    logic [OW-1:0] b_reg, b_next;
    logic          out_valid_reg, out_valid_next;
    logic [OW-1:0] vio_reg, vio_next;
    logic [OW-1:0] maxv_reg, maxv_next;

    logic signed [VALUE_WIDTH-1:0] dl, dh;
    logic [OW-1:0] g_dl_hi, g_dl_lo, g_lo_dh, g_hi_dh, g_lo_prev;
    logic          at_last, finish, out_free;
    logic [OW-1:0] res_a, res_b, upd_a, upd_b;

    assign dl = rdata[VALUE_WIDTH-1:0];
    assign dh = rdata[2*VALUE_WIDTH-1:VALUE_WIDTH];

    assign g_dl_hi   = gap(dl, hi_reg);
    assign g_dl_lo   = gap(dl, lo_reg);
    assign g_lo_dh   = gap(lo_reg, dh);
    assign g_hi_dh   = gap(hi_reg, dh);
    assign g_lo_prev = gap(lo_reg, prev_reg);

    assign at_last  = (idx_reg == last_reg);
    assign out_free = !out_valid_reg || out_ready;

    // evaluate the entry that the table presents this cycle
    always_comb
    begin
        finish = at_last;
        res_a  = '0;
        res_b  = '0;
        upd_a  = a_reg;
        upd_b  = b_reg;
        if (range_reg)
        begin
            if (hi_reg < dl)
            begin
                upd_a  = umin(a_reg, g_dl_hi);
                upd_b  = umin(b_reg, g_dl_lo);
                finish = 1'b1;
            end
            else if (lo_reg <= dh)
            begin
                upd_a = '0;
                if (lo_reg < dl)
                    upd_b = umin(b_reg, g_dl_lo);
                else if (dh < hi_reg)
                    upd_b = umin(b_reg, g_hi_dh);
                else
                    upd_b = '0;
            end
            else
            begin
                upd_a = umin(a_reg, g_lo_dh);
                upd_b = umin(b_reg, g_hi_dh);
            end
            res_a = upd_a;
            res_b = upd_b;
        end
        else
        begin
            // a value below the first low end stops at once, whatever its high end
            if ((idx_reg == '0) && (lo_reg < dl))
            begin
                finish = 1'b1;
                res_a  = g_dl_lo;
            end
            else if (lo_reg > dh)
            begin
                res_a = g_lo_dh;
            end
            else if (lo_reg < dl)
            begin
                finish = 1'b1;
                res_a  = umin(g_lo_prev, g_dl_lo);
            end
            else
            begin
                finish = 1'b1;
                res_a  = '0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        range_next     = range_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        prev_next      = prev_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        vio_next       = vio_reg;
        maxv_next      = maxv_reg;
        out_valid_next = out_valid_reg && !out_ready;
        re             = 1'b0;
        raddr          = '0;
        case (state_reg)
            isdv_pkg::ST_IDLE:
            begin
                if (cmd.start)
                begin
                    re         = 1'b1;
                    raddr      = '0;
                    idx_next   = '0;
                    last_next  = last_index;
                    range_next = cmd.is_range;
                    lo_next    = arg_low;
                    hi_next    = arg_high;
                    a_next     = isdv_pkg::OUT_MAX;
                    b_next     = isdv_pkg::OUT_MAX;
                    state_next = isdv_pkg::ST_WALK;
                end
            end
            isdv_pkg::ST_WALK:
            begin
                if (finish)
                begin
                    // hold the entry until the output slot frees up
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        vio_next       = res_a;
                        maxv_next      = res_b;
                        state_next     = isdv_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    re        = 1'b1;
                    raddr     = AW'(idx_reg + 1'b1);
                    idx_next  = AW'(idx_reg + 1'b1);
                    prev_next = dh;
                    a_next    = upd_a;
                    b_next    = upd_b;
                end
            end
            default:
            begin
                state_next = isdv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isdv_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        last_reg  <= last_next;
        range_reg <= range_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        prev_reg  <= prev_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        vio_reg   <= vio_next;
        maxv_reg  <= maxv_next;
    end

    assign busy          = (state_reg != isdv_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign violation     = vio_reg;
    assign max_violation = maxv_reg;

endmodule

FILE: src/interval_set_distance_violation.sv
// Loads give no item. A query walks the table one entry per cycle through the
// table's single read port. Its result waits in the walk until the output register
// frees up, and the next item is taken the cycle after the walk ends, so the block
// takes no new item while a query is still in progress.
// Reset clears control state and sets interval_count to 1; the table is not cleared.
module interval_set_distance_violation #(
    parameter int MAX_INTERVALS = isdv_pkg::MAX_INTERVALS_DEF,
    parameter int VALUE_WIDTH   = isdv_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,   // interval_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,     // entry_index[3:0], arg_low[35:4], arg_high[67:36], zero
    input  logic [1:0]  s_tuser,     // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata      // violation[31:0], max_violation[63:32]
);

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam logic [AW-1:0] LAST_MAX = AW'(MAX_INTERVALS - 1);

    logic [isdv_pkg::CNT_WIDTH-1:0] count_reg;
    logic [AW-1:0] last_index;
    logic [3:0]    entry_index;
    logic signed [VALUE_WIDTH-1:0] arg_low, arg_high;
    logic          accept, busy, table_we, walk_re;
    logic [AW-1:0] walk_raddr;
    logic [2*VALUE_WIDTH-1:0] table_rdata;
    isdv_pkg::walk_cmd_t cmd;
    logic [isdv_pkg::OUT_WIDTH-1:0] violation, max_violation;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= isdv_pkg::CNT_RESET;
        else if (cfg_we)
            count_reg <= cfg_wdata;
    end

    // a count of zero walks one entry, a count past the table walks all of it
    always_comb
    begin
        if (count_reg == '0)
            last_index = '0;
        else if (32'(count_reg) > 32'(MAX_INTERVALS))
            last_index = LAST_MAX;
        else
            last_index = AW'(count_reg - 1'b1);
    end

    assign entry_index = s_tdata[3:0];
    assign arg_low     = VALUE_WIDTH'(s_tdata[35:4]);
    assign arg_high    = VALUE_WIDTH'(s_tdata[67:36]);

    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        table_we     = 1'b0;
        cmd.start    = 1'b0;
        cmd.is_range = 1'b0;
        case (s_tuser)
            isdv_pkg::MODE_LOAD:
            begin
                table_we = accept && (32'(entry_index) < 32'(MAX_INTERVALS));
            end
            isdv_pkg::MODE_VALUE:
            begin
                cmd.start = accept;
            end
            isdv_pkg::MODE_RANGE:
            begin
                cmd.start    = accept;
                cmd.is_range = 1'b1;
            end
            default:
            begin
                table_we = 1'b0;
            end
        endcase
    end

    isdv_table #(
        .DEPTH (MAX_INTERVALS),
        .WIDTH (2 * VALUE_WIDTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (table_we),
        .waddr (AW'(entry_index)),
        .wdata ({arg_high, arg_low}),
        .re    (walk_re),
        .raddr (walk_raddr),
        .rdata (table_rdata)
    );

    isdv_walk #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .VALUE_WIDTH   (VALUE_WIDTH),
        .AW            (AW)
    ) u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .arg_low       (arg_low),
        .arg_high      (arg_high),
        .last_index    (last_index),
        .rdata         (table_rdata),
        .re            (walk_re),
        .raddr         (walk_raddr),
        .busy          (busy),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .violation     (violation),
        .max_violation (max_violation)
    );

    assign m_tdata = {max_violation, violation};

endmodule
